// ----- rtl/core/ofd_pkg.sv -----
// ----------------------------------------------------------------------------
// ofd_pkg
// Shared types and constants of the occupancy frontier detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ofd_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH   = 3'd0,
    REG_GRID_HEIGHT  = 3'd1,
    REG_FREE_CODE    = 3'd2,
    REG_UNKNOWN_CODE = 3'd3
  } cfg_reg_e;

  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Bits of a 2-bit cell class
  localparam int unsigned CLS_FREE_BIT = 0;
  localparam int unsigned CLS_UNK_BIT  = 1;

  typedef struct packed {
    logic              kind;
    logic signed [7:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic is_frontier;
    logic last_of_map;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/ofd_ram.sv -----
// ----------------------------------------------------------------------------
// ofd_ram
// Simple dual-port RAM: one write port, one read port with registered,
// read-first data that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module ofd_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/occupancy_frontier_detect_core.sv -----
// ----------------------------------------------------------------------------
// occupancy_frontier_detect_core
// Marks free cells of a raster-order occupancy grid that touch an unknown
// cell through one of their four direct neighbors.
// ----------------------------------------------------------------------------
//  channel | signals                            | direction | word
//  --------+------------------------------------+-----------+-----------------
//  in      | in_valid_i/in_ready_o/in_data_i    | input     | kind, cell_value
//  out     | out_valid_o/out_ready_i/out_data_o | output    | is_frontier, last
//  cfg     | cfg_we_i/cfg_idx_i/cfg_data_i      | input     | register write
//
//  One word is accepted per cycle unless the input stalls. The word that
//  completes a result sends it through s1 to the output register; rate is
//  set by the line RAM, which takes one read and one write per cycle.
//  Each RAM column holds the classes of the two rows above the input.
//  Reset needs no clearing pass; unwritten line RAM contents never affect a result.
//  Input stalls only while the output register is held and a second result
//  waits behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_frontier_detect_core
  import ofd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  // Configuration
  logic [10:0]       grid_width_q;
  logic [12:0]       grid_height_q;
  logic signed [7:0] free_code_q;
  logic signed [7:0] unknown_code_q;
  logic              cfg_hit;
  logic [WW-1:0]     eff_w;
  logic [HW-1:0]     eff_h;

  // Stream position
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic          done_q, done_d;

  logic [WW-1:0] in_col_inc, out_col_inc;
  logic [HW-1:0] in_row_inc, out_row_inc;
  logic          in_row_end, in_last_row, has_right, out_last;

  // Handshake and datapath
  logic          accept, is_push, do_push, do_flush, report;
  logic [1:0]    cls;
  logic [3:0]    pre;
  logic          unk;
  logic          can_adv;

  logic          ram_re;
  logic [CW-1:0] ram_raddr;
  logic [3:0]    ram_wdata;
  logic [3:0]    ram_rdata;

  logic          fwd_q;
  logic [3:0]    fwd_data_q;
  logic          prev_unk_q;

  logic          s1_valid_q;
  logic          s1_free_q, s1_unk_q, s1_right_q, s1_last_q;
  logic          out_valid_q;
  out_item_t     out_q;

  // Clamp width and height to the supported range
  always_comb begin
    if (grid_width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(grid_width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(grid_width_q);
    end
    if (grid_height_q == '0) begin
      eff_h = HW'(1);
    end else if (32'(grid_height_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(grid_height_q);
    end
  end

  assign cfg_hit = (cfg_idx_i == REG_GRID_WIDTH) || (cfg_idx_i == REG_GRID_HEIGHT) ||
                   (cfg_idx_i == REG_FREE_CODE) || (cfg_idx_i == REG_UNKNOWN_CODE);

  assign can_adv    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || can_adv;

  assign accept   = in_valid_i && in_ready_o;
  assign is_push  = (in_data_i.kind == KIND_CELL);
  assign do_push  = accept && is_push && !done_q;
  assign do_flush = accept && !is_push && done_q;
  assign report   = (do_push && (in_row_q != '0)) || do_flush;

  always_comb begin
    cls = '0;
    cls[CLS_FREE_BIT] = (in_data_i.cell_value == free_code_q);
    cls[CLS_UNK_BIT]  = (in_data_i.cell_value == unknown_code_q);
  end

  assign in_col_inc  = WW'(in_col_q) + WW'(1);
  assign in_row_inc  = HW'(in_row_q) + HW'(1);
  assign in_row_end  = (in_col_inc >= eff_w);
  assign in_last_row = (in_row_inc >= eff_h);

  assign out_col_inc = WW'(out_col_q) + WW'(1);
  assign out_row_inc = HW'(out_row_q) + HW'(1);
  assign has_right   = (out_col_inc < eff_w);
  assign out_last    = (out_row_inc >= eff_h) && !has_right;

  // Column entry of the reported cell: {class two rows up, class one row up}
  assign pre = fwd_q ? fwd_data_q : ram_rdata;

  assign unk = ((out_row_q != '0) && pre[2+CLS_UNK_BIT]) ||
               ((out_col_q != '0) && prev_unk_q) ||
               (do_push && cls[CLS_UNK_BIT]);

  // Prefetch the next column; it is the right neighbor of this cell
  assign ram_re    = do_push || do_flush;
  assign ram_wdata = {pre[1:0], cls};
  always_comb begin
    if (do_push) begin
      ram_raddr = in_row_end ? '0 : CW'(in_col_inc);
    end else begin
      ram_raddr = has_right ? CW'(out_col_inc) : '0;
    end
  end

  ofd_ram #(
    .Width (4),
    .Depth (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (in_col_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    done_d    = done_q;
    if (cfg_we_i && cfg_hit) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      done_d    = 1'b0;
    end else begin
      if (do_push) begin
        if (in_row_end) begin
          in_col_d = '0;
          if (in_last_row) begin
            in_row_d = '0;
            done_d   = 1'b1;
          end else begin
            in_row_d = RW'(in_row_inc);
          end
        end else begin
          in_col_d = CW'(in_col_inc);
        end
      end
      if (report) begin
        if (out_last) begin
          // End of map: restart for the next one
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
          done_d    = 1'b0;
        end else if (!has_right) begin
          out_col_d = '0;
          out_row_d = RW'(out_row_inc);
        end else begin
          out_col_d = CW'(out_col_inc);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q   <= 11'd1024;
      grid_height_q  <= 13'd1;
      free_code_q    <= 8'sd0;
      unknown_code_q <= -8'sd1;
      in_col_q       <= '0;
      in_row_q       <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      done_q         <= 1'b0;
      fwd_q          <= 1'b0;
      prev_unk_q     <= 1'b0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_WIDTH:   grid_width_q   <= cfg_data_i[10:0];
          REG_GRID_HEIGHT:  grid_height_q  <= cfg_data_i[12:0];
          REG_FREE_CODE:    free_code_q    <= cfg_data_i[7:0];
          REG_UNKNOWN_CODE: unknown_code_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      done_q    <= done_d;
      // Forward a write that lands on the column read in the same cycle
      if (ram_re) begin
        fwd_q <= do_push && (ram_raddr == in_col_q);
      end
      if (report) begin
        prev_unk_q <= pre[CLS_UNK_BIT];
      end
      if (report) begin
        s1_valid_q <= 1'b1;
      end else if (can_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (can_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      fwd_data_q <= ram_wdata;
    end
    if (report) begin
      s1_free_q  <= pre[CLS_FREE_BIT];
      s1_unk_q   <= unk;
      s1_right_q <= has_right;
      s1_last_q  <= out_last;
    end
    // Right neighbor arrives from the RAM in the cycle after the report
    if (can_adv && s1_valid_q) begin
      out_q.is_frontier <= s1_free_q && (s1_unk_q || (s1_right_q && ram_rdata[CLS_UNK_BIT]));
      out_q.last_of_map <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/ofd_checker.sv -----
// ----------------------------------------------------------------------------
// ofd_checker
// Port-level checks of the occupancy frontier detector, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ofd_checker
  import ofd_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_acc, 2))
    else $error("result without a word accepted two cycles before");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output is free");

endmodule

bind occupancy_frontier_detect_core ofd_checker u_ofd_checker (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams occupancy maps of many sizes and code settings through the frontier
// detector with random idling on both channels, predicts every frontier mark
// in a scoreboard and compares the marks the block returns in order.
// ----------------------------------------------------------------------------

module tb_top;
  import ofd_pkg::*;

  localparam int unsigned MAX_W = MAX_WIDTH_DEF;
  localparam int unsigned MAX_H = MAX_HEIGHT_DEF;
  localparam int TAIL_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_FIRST = REG_UNKNOWN_CODE + 1;

  // Predicts frontier marks from accepted words and checks returned marks.
  class frontier_tracker;
    bit [1:0]    class_rows [2*MAX_W];
    int unsigned in_col, in_row, out_col, out_row;
    bit          input_done;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [7:0]  free_code, unknown_code;
    out_item_t   pending_marks [$];
    int          fail_count;

    function new();
      width_reg    = 11'd1024;
      height_reg   = 13'd1;
      free_code    = 8'h00;
      unknown_code = 8'hFF;
      fail_count   = 0;
      restart();
    endfunction

    function void restart();
      in_col     = 0;
      in_row     = 0;
      out_col    = 0;
      out_row    = 0;
      input_done = 1'b0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_H) return MAX_H;
      return height_reg;
    endfunction

    function int unsigned slot(int unsigned row, int unsigned col);
      return (row % 2) * MAX_W + col;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GRID_WIDTH:   width_reg = data[10:0];
        REG_GRID_HEIGHT:  height_reg = data[12:0];
        REG_FREE_CODE:    free_code = data[7:0];
        REG_UNKNOWN_CODE: unknown_code = data[7:0];
        default:          return;
      endcase
      restart();
    endfunction

    // Mark the cell at the output position; the cell below is given when present.
    function void emit_mark(bit has_below, bit [1:0] below_cls);
      int unsigned w, h, r, c;
      bit [1:0]    own;
      bit          unk;
      out_item_t   mark;
      w   = eff_width();
      h   = eff_height();
      r   = out_row;
      c   = out_col;
      own = class_rows[slot(r, c)];
      unk = 1'b0;
      if (r > 0 && class_rows[slot(r - 1, c)][CLS_UNK_BIT]) unk = 1'b1;
      if (c > 0 && class_rows[slot(r, c - 1)][CLS_UNK_BIT]) unk = 1'b1;
      if (c + 1 < w && class_rows[slot(r, c + 1)][CLS_UNK_BIT]) unk = 1'b1;
      if (has_below && below_cls[CLS_UNK_BIT]) unk = 1'b1;
      mark.is_frontier = own[CLS_FREE_BIT] && unk;
      mark.last_of_map = (r + 1 >= h) && (c + 1 >= w);
      pending_marks.insert(pending_marks.size(), mark);
      if (mark.last_of_map) begin
        restart();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void note_word(in_item_t word);
      bit [1:0] cls;
      if (word.kind == KIND_FLUSH) begin
        if (input_done) emit_mark(1'b0, 2'b00);
        return;
      end
      if (input_done) return;
      cls = 2'b00;
      if (word.cell_value == free_code) cls[CLS_FREE_BIT] = 1'b1;
      if (word.cell_value == unknown_code) cls[CLS_UNK_BIT] = 1'b1;
      // the cell above is complete once its lower neighbor shows up
      if (in_row > 0) emit_mark(1'b1, cls);
      class_rows[slot(in_row, in_col)] = cls;
      in_col++;
      if (in_col >= eff_width()) begin
        in_col = 0;
        in_row++;
        if (in_row >= eff_height()) begin
          in_row     = 0;
          input_done = 1'b1;
        end
      end
    endfunction

    function void check_mark(out_item_t got);
      out_item_t want;
      if (pending_marks.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected mark: frontier=%0b last=%0b", got.is_frontier, got.last_of_map);
        return;
      end
      want = pending_marks.pop_front();
      if (got.is_frontier !== want.is_frontier || got.last_of_map !== want.last_of_map) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mark mismatch: expected frontier=%0b last=%0b, got frontier=%0b last=%0b",
                   want.is_frontier, want.last_of_map, got.is_frontier, got.last_of_map);
      end
    endfunction

    function int marks_due();
      return pending_marks.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  frontier_tracker tracker = new();

  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left = 0;
  int          hold_asked = 0;
  int          hold_taken = 0;
  int unsigned cur_w, cur_h;
  logic [7:0]  cur_free, cur_unk;
  int          cells_pushed;

  occupancy_frontier_detect_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  // Receiver: random stalls, or a long hold-off while hold_left runs down.
  always @(posedge clk) begin
    if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) tracker.check_mark(out_data);
      if (in_valid && in_ready) tracker.note_word(in_data);
    end
  end

  task automatic send_word(input logic kind, input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, cell_value: value};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and hold until every expected mark is back and the pipe is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.marks_due() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [10:0] w_raw, input logic [12:0] h_raw,
                             input logic [7:0] fc, input logic [7:0] uc);
    wait_idle();
    write_reg(REG_GRID_WIDTH, {2'($urandom), w_raw});
    write_reg(REG_GRID_HEIGHT, h_raw);
    write_reg(REG_FREE_CODE, {5'($urandom), fc});
    write_reg(REG_UNKNOWN_CODE, {5'($urandom), uc});
    cur_w    = (w_raw == 0) ? 1 : ((w_raw > MAX_W) ? MAX_W : w_raw);
    cur_h    = (h_raw == 0) ? 1 : ((h_raw > MAX_H) ? MAX_H : h_raw);
    cur_free = fc;
    cur_unk  = uc;
  endtask

  function automatic logic [7:0] pick_cell();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return cur_free;
    if (roll < 70) return cur_unk;
    return 8'($urandom);
  endfunction

  // Push one map with some ignored words mixed in, then flush its last row.
  // A nonzero cut abandons the map after that many cells.
  task automatic play_map(input int cut);
    int cells;
    cells = cur_w * cur_h;
    for (int i = 0; i < cells; i++) begin
      if ($urandom_range(99) < 2) send_word(KIND_FLUSH, 8'($urandom));
      send_word(KIND_CELL, pick_cell());
      cells_pushed++;
      if (cut != 0 && i + 1 == cut) return;
      if ($urandom_range(999) < 4) wait_idle();
    end
    if ($urandom_range(99) < 10) send_word(KIND_CELL, 8'($urandom));
    repeat (cur_w) send_word(KIND_FLUSH, 8'($urandom));
    if ($urandom_range(99) < 10) send_word(KIND_FLUSH, 8'($urandom));
  endtask

  task automatic random_phase(input int goal, input bit with_hold);
    bit          need_cfg;
    bit          first;
    logic [10:0] w_raw;
    logic [12:0] h_raw;
    logic [7:0]  fc, uc;
    int          cut;
    cells_pushed = 0;
    need_cfg     = 1'b1;
    first        = 1'b1;
    while (cells_pushed < goal) begin
      if (need_cfg || $urandom_range(99) < 50) begin
        w_raw = ($urandom_range(99) < 5) ? 11'd0 : 11'($urandom_range(12, 1));
        h_raw = ($urandom_range(99) < 5) ? 13'd0 : 13'($urandom_range(8, 1));
        fc    = 8'($urandom);
        uc    = ($urandom_range(99) < 10) ? fc : 8'($urandom);
        if ($urandom_range(99) < 10) begin
          fc = 8'h80;
          uc = 8'h7F;
        end
        if (first && with_hold) begin
          w_raw = 11'd10;
          h_raw = 13'd12;
        end
        load_config(w_raw, h_raw, fc, uc);
        // stall the receiver for a long stretch while cells keep coming
        if (first && with_hold) hold_asked++;
        need_cfg = 1'b0;
      end
      cut = 0;
      if (cur_w * cur_h > 1 && $urandom_range(99) < 8) cut = $urandom_range(cur_w * cur_h - 1, 1);
      play_map(cut);
      if (cut != 0) need_cfg = 1'b1;
      first = 1'b0;
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    send_idle_pct = 26;
    recv_idle_pct = 50;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // flush with no map complete: no mark
    send_word(KIND_FLUSH, 8'h00);
    // 3x3 map with a pause and an unused register write mid-map
    load_config(11'd3, 13'd3, 8'h00, 8'hFF);
    send_word(KIND_CELL, 8'hFF);
    send_word(KIND_CELL, 8'h00);
    send_word(KIND_CELL, 8'h00);
    send_word(KIND_CELL, 8'h00);
    wait_idle();
    write_reg(3'($urandom_range(2**CFG_IDX_W - 1, REG_NONE_FIRST)), 13'($urandom));
    send_word(KIND_CELL, 8'h00);
    send_word(KIND_CELL, 8'h7F);
    send_word(KIND_CELL, 8'h80);
    send_word(KIND_CELL, 8'h00);
    send_word(KIND_CELL, 8'hFF);
    // push after the map is complete: dropped
    send_word(KIND_CELL, 8'h7F);
    repeat (3) send_word(KIND_FLUSH, 8'hFF);
    // flush after the last mark: dropped
    send_word(KIND_FLUSH, 8'h00);
    // free and unknown codes equal
    load_config(11'd2, 13'd1, 8'h05, 8'h05);
    send_word(KIND_CELL, 8'h05);
    send_word(KIND_CELL, 8'h05);
    repeat (2) send_word(KIND_FLUSH, 8'h00);
    // zero width and height act as one
    load_config(11'd0, 13'd0, 8'h80, 8'h7F);
    send_word(KIND_CELL, 8'h80);
    send_word(KIND_FLUSH, 8'h00);

    random_phase(180, 1'b1);

    wait_idle();
    send_idle_pct = 50;
    recv_idle_pct = 26;
    random_phase(180, 1'b1);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // width above the limit wraps rows at the largest width
    load_config(11'd2047, 13'd2, 8'h00, 8'hFF);
    play_map(MAX_W + 6);
    random_phase(120, 1'b0);

    wait_idle();
    if (tracker.fail_count == 0 && tracker.marks_due() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ofd_pkg.sv
rtl/core/ofd_ram.sv
rtl/core/occupancy_frontier_detect_core.sv
rtl/core/ofd_checker.sv
dv/tb_top.sv
